>>> hdl/hds_pkg.sv
// Shared types and constants for the heat diffusion stencil block.
// No dependencies; compiled first.
package hds_pkg;

  // Field widths fixed by the item formats
  localparam int TEMP_BITS      = 16;
  localparam int GAIN_BITS      = 16;
  localparam int GAIN_FRAC      = 16;
  localparam int WIDTH_BITS     = 11;
  localparam int HEIGHT_BITS    = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIFFUSION_GAIN = 2'd2;

  // Register reset values
  localparam logic [WIDTH_BITS-1:0]  GRID_WIDTH_RST     = 11'd1024;
  localparam logic [HEIGHT_BITS-1:0] GRID_HEIGHT_RST    = 16'd1024;
  localparam logic [GAIN_BITS-1:0]   DIFFUSION_GAIN_RST = 16'd16384;

  // Input commands
  localparam logic CMD_CELL  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Saturation limits
  localparam logic signed [TEMP_BITS-1:0] TEMP_MAX = {1'b0, {(TEMP_BITS-1){1'b1}}};
  localparam logic signed [TEMP_BITS-1:0] TEMP_MIN = {1'b1, {(TEMP_BITS-1){1'b0}}};

  typedef struct packed {
    logic                        cmd;
    logic signed [TEMP_BITS-1:0] temp_in;
  } in_item_t;

  typedef struct packed {
    logic signed [TEMP_BITS-1:0] temp_out;
    logic                        last;
  } out_item_t;

  // Which neighbours exist; a missing one is replaced by the center value
  typedef struct packed {
    logic has_north;
    logic has_west;
    logic has_east;
    logic south_is_ctr;
  } nbr_sel_t;

endpackage

>>> hdl/hds_line_buf.sv
// Two line buffers (previous row and the row before it) with registered reads.
// Depends on hds_pkg. Same-edge writes are forwarded to the read registers.
module hds_line_buf #(
  parameter int DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr,
  output logic signed [hds_pkg::TEMP_BITS-1:0] ctr_q,
  output logic signed [hds_pkg::TEMP_BITS-1:0] east_q,
  output logic signed [hds_pkg::TEMP_BITS-1:0] north_q,
  input  logic                                wr_north,
  input  logic                                wr_center,
  input  logic [$clog2(DEPTH)-1:0]            wr_addr,
  input  logic signed [hds_pkg::TEMP_BITS-1:0] wr_north_data,
  input  logic signed [hds_pkg::TEMP_BITS-1:0] wr_center_data
);
  import hds_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic signed [TEMP_BITS-1:0] north_mem  [DEPTH];
  logic signed [TEMP_BITS-1:0] center_mem [DEPTH];
  logic [AW-1:0]               east_addr;

  // east neighbour address; the last column never uses it
  assign east_addr = (32'(rd_addr) == DEPTH - 1) ? rd_addr : AW'(rd_addr + 1'b1);

  always_ff @(posedge clk) begin
    if (wr_north) begin
      north_mem[wr_addr] <= wr_north_data;
    end
    if (wr_center) begin
      center_mem[wr_addr] <= wr_center_data;
    end
    if (rd_en) begin
      ctr_q   <= (wr_center && wr_addr == rd_addr) ? wr_center_data : center_mem[rd_addr];
      east_q  <= (wr_center && wr_addr == east_addr) ? wr_center_data : center_mem[east_addr];
      north_q <= (wr_north && wr_addr == rd_addr) ? wr_north_data : north_mem[rd_addr];
    end
  end

endmodule

>>> hdl/hds_stencil.sv
// Five-point update: c + floor(gain * (N + S + E + W - 4c) / 2^16), saturated.
// Depends on hds_pkg. Purely combinational.
module hds_stencil (
  input  logic signed [hds_pkg::TEMP_BITS-1:0] ctr,
  input  logic signed [hds_pkg::TEMP_BITS-1:0] north,
  input  logic signed [hds_pkg::TEMP_BITS-1:0] south,
  input  logic signed [hds_pkg::TEMP_BITS-1:0] east,
  input  logic signed [hds_pkg::TEMP_BITS-1:0] west,
  input  hds_pkg::nbr_sel_t                    sel,
  input  logic [hds_pkg::GAIN_BITS-1:0]        gain,
  output logic signed [hds_pkg::TEMP_BITS-1:0] temp_new
);
  import hds_pkg::*;

  localparam int LAP_W  = TEMP_BITS + 3;
  localparam int PROD_W = LAP_W + GAIN_BITS + 1;
  localparam int QUO_W  = PROD_W - GAIN_FRAC;
  localparam int SUM_W  = QUO_W + 1;

  logic signed [TEMP_BITS-1:0] n_v, s_v, e_v, w_v;
  logic signed [LAP_W-1:0]     lap;
  logic signed [PROD_W-1:0]    prod;
  logic signed [QUO_W-1:0]     quo;
  logic signed [SUM_W-1:0]     sum;
  logic [SUM_W-TEMP_BITS:0]    top_bits;

  // border substitution
  assign n_v = sel.has_north    ? north : ctr;
  assign s_v = sel.south_is_ctr ? ctr   : south;
  assign e_v = sel.has_east     ? east  : ctr;
  assign w_v = sel.has_west     ? west  : ctr;

  // Laplacian, gain product, floor by arithmetic shift
  assign lap  = LAP_W'(n_v) + LAP_W'(s_v) + LAP_W'(e_v) + LAP_W'(w_v)
              - (LAP_W'(ctr) <<< 2);
  assign prod = PROD_W'(lap) * PROD_W'($signed({1'b0, gain}));
  assign quo  = $signed(prod[PROD_W-1:GAIN_FRAC]);
  assign sum  = SUM_W'(ctr) + SUM_W'(quo);

  // saturate: all bits from the sign of the result upward must agree
  assign top_bits = sum[SUM_W-1:TEMP_BITS-1];

  always_comb begin
    if (top_bits == '0 || top_bits == '1) begin
      temp_new = sum[TEMP_BITS-1:0];
    end else if (sum[SUM_W-1]) begin
      temp_new = TEMP_MIN;
    end else begin
      temp_new = TEMP_MAX;
    end
  end

endmodule

>>> hdl/heat_diffusion_stencil_step.sv
// Top level of the five-point heat diffusion stencil, one explicit time step.
// Depends on hds_pkg, hds_line_buf and hds_stencil.
//
// Usage:
//   The grid streams in row-major order on the item channel (cmd = cell),
//   one cell per item. Each cell of row r yields the updated value of the
//   same column of row r-1 on the result channel; row 0 yields nothing.
//   After the whole grid, one drain item per column flushes the last row;
//   the drain of the last column flags last and rearms the block for the
//   next grid. Cells beyond the grid and drains before the grid is complete
//   are taken and dropped.
//   Throughput is one item per cycle unless the result side stalls.
//   An item's result enters the result register as it leaves the read
//   stage: the line buffer read port registers its data on the accept
//   edge, and the stencil math sits between it and the result register.
//   When the result side stalls, one item waits in the read stage and the
//   input holds ready low only once that stage is blocked.
//   Reset empties the pipeline, clears the row, column and drain counters
//   and loads the register defaults; line buffer contents are not cleared.
//   Configuration is written through cfg_we / cfg_index / cfg_data.
module heat_diffusion_stencil_step #(
  parameter int MAX_COLS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [hds_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [hds_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  hds_pkg::in_item_t                    item,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output hds_pkg::out_item_t                   result
);
  import hds_pkg::*;

  localparam int CW = $clog2(MAX_COLS);

  typedef struct packed {
    logic     produce;
    logic     is_drain;
    logic     fin;
    nbr_sel_t sel;
  } stage_ctl_t;

  // configuration registers
  logic [WIDTH_BITS-1:0]  grid_width;
  logic [HEIGHT_BITS-1:0] grid_height;
  logic [GAIN_BITS-1:0]   diffusion_gain;

  // stream position
  logic [CW-1:0]          col_count, col_count_next;
  logic [CW-1:0]          drain_count, drain_count_next;
  logic [HEIGHT_BITS-1:0] row_count, row_count_next;

  logic [CW:0]            width_eff;
  logic [HEIGHT_BITS-1:0] height_eff;
  logic [CW:0]            cell_inc, drain_inc;

  // accept decode
  logic                   accept;
  logic                   work;
  logic [CW-1:0]          col_sel;
  stage_ctl_t             ctl_next;

  // read stage
  logic                        a_valid;
  stage_ctl_t                  a_ctl;
  logic [CW-1:0]               a_col;
  logic signed [TEMP_BITS-1:0] a_temp;
  logic signed [TEMP_BITS-1:0] prev_ctr;
  logic                        a_move;
  logic                        out_free;

  logic signed [TEMP_BITS-1:0] ctr_raw, east_raw, north_raw;
  logic signed [TEMP_BITS-1:0] temp_new;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= GRID_WIDTH_RST;
      grid_height    <= GRID_HEIGHT_RST;
      diffusion_gain <= DIFFUSION_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:     grid_width     <= cfg_data[WIDTH_BITS-1:0];
        REG_GRID_HEIGHT:    grid_height    <= cfg_data[HEIGHT_BITS-1:0];
        REG_DIFFUSION_GAIN: diffusion_gain <= cfg_data[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective grid size: zero counts as one, width clamps to the buffer depth
  always_comb begin
    if (grid_width == '0) begin
      width_eff = (CW+1)'(1);
    end else if (32'(grid_width) > MAX_COLS) begin
      width_eff = (CW+1)'(MAX_COLS);
    end else begin
      width_eff = (CW+1)'(grid_width);
    end
  end

  assign height_eff = (grid_height == '0) ? HEIGHT_BITS'(1) : grid_height;
  assign cell_inc   = (CW+1)'({1'b0, col_count}) + (CW+1)'(1);
  assign drain_inc  = (CW+1)'({1'b0, drain_count}) + (CW+1)'(1);

  // handshake
  assign out_free   = !result_valid || result_ready;
  assign a_move     = a_valid && (!a_ctl.produce || out_free);
  assign item_ready = !a_valid || a_move;
  assign accept     = item_valid && item_ready;

  // decode the arriving item against the stream position
  always_comb begin
    ctl_next         = '0;
    work             = 1'b0;
    col_sel          = col_count;
    col_count_next   = col_count;
    row_count_next   = row_count;
    drain_count_next = drain_count;
    if (item.cmd == CMD_CELL) begin
      if (row_count < height_eff) begin
        work                  = 1'b1;
        ctl_next.produce      = (row_count != '0);
        ctl_next.sel.has_north = (row_count > HEIGHT_BITS'(1));
        ctl_next.sel.has_west = (col_count != '0);
        ctl_next.sel.has_east = (cell_inc < width_eff);
        if (cell_inc >= width_eff) begin
          col_count_next = '0;
          row_count_next = row_count + 1'b1;
        end else begin
          col_count_next = cell_inc[CW-1:0];
        end
      end
    end else begin
      if (row_count >= height_eff) begin
        work                      = 1'b1;
        col_sel                   = drain_count;
        ctl_next.produce          = 1'b1;
        ctl_next.is_drain         = 1'b1;
        ctl_next.fin              = (drain_inc >= width_eff);
        ctl_next.sel.has_north    = (height_eff > HEIGHT_BITS'(1));
        ctl_next.sel.has_west     = (drain_count != '0);
        ctl_next.sel.has_east     = (drain_inc < width_eff);
        ctl_next.sel.south_is_ctr = 1'b1;
        if (drain_inc >= width_eff) begin
          col_count_next   = '0;
          row_count_next   = '0;
          drain_count_next = '0;
        end else begin
          drain_count_next = drain_inc[CW-1:0];
        end
      end
    end
  end

  // stream position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_count   <= '0;
      drain_count <= '0;
    end else if (accept) begin
      col_count   <= col_count_next;
      row_count   <= row_count_next;
      drain_count <= drain_count_next;
    end
  end

  // read stage: dropped items never enter it
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item_ready) begin
      a_valid <= accept && work;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_ctl  <= ctl_next;
      a_col  <= col_sel;
      a_temp <= item.temp_in;
    end
    // west neighbour is the previous column's center value
    if (a_move) begin
      prev_ctr <= ctr_raw;
    end
  end

  hds_line_buf #(
    .DEPTH (MAX_COLS)
  ) u_line_buf (
    .clk            (clk),
    .rd_en          (accept),
    .rd_addr        (col_sel),
    .ctr_q          (ctr_raw),
    .east_q         (east_raw),
    .north_q        (north_raw),
    .wr_north       (a_move),
    .wr_center      (a_move && !a_ctl.is_drain),
    .wr_addr        (a_col),
    .wr_north_data  (ctr_raw),
    .wr_center_data (a_temp)
  );

  hds_stencil u_stencil (
    .ctr      (ctr_raw),
    .north    (north_raw),
    .south    (a_temp),
    .east     (east_raw),
    .west     (prev_ctr),
    .sel      (a_ctl.sel),
    .gain     (diffusion_gain),
    .temp_new (temp_new)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (a_move && a_ctl.produce) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move && a_ctl.produce) begin
      result.temp_out <= temp_new;
      result.last     <= a_ctl.fin;
    end
  end

  // the final drain has already rearmed the counters
  a_fin_rearmed: assert property (@(posedge clk) disable iff (rst)
    a_valid && a_ctl.fin |-> col_count == '0 && row_count == '0 && drain_count == '0)
    else $error("final drain in flight but counters not cleared");

  // a drain before the grid is complete leaves nothing behind
  a_early_drain: assert property (@(posedge clk) disable iff (rst)
    accept && item.cmd == CMD_DRAIN && row_count < height_eff |=> !a_valid)
    else $error("early drain entered the pipeline");

  // items without a result never block the input
  a_no_result_flows: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_ctl.produce |-> item_ready)
    else $error("resultless item stalled the input");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid && !a_valid)
    else $error("pipeline not empty after reset");

endmodule
